FILE: hdl/sha1_stream_hasher_core_assert.svh
// Assertion macros used by the hasher control block (sha1sh_ctrl).
`ifndef SHA1_STREAM_HASHER_CORE_ASSERT_SVH
`define SHA1_STREAM_HASHER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SHA1SH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define SHA1SH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/sha1sh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sha1sh_pkg;

  localparam int NumRounds   = 80;
  localparam int NumWords    = 5;
  localparam int SchedWords  = 16;
  localparam int RoundWidth  = $clog2(NumRounds);
  localparam int WordIdxW    = 3;

  localparam logic [5:0]          LastBytePos = 6'd63;
  localparam logic [5:0]          LenBytePos  = 6'd56;
  localparam logic [7:0]          PadMark     = 8'h80;
  localparam logic [WordIdxW-1:0] LastWordIdx = WordIdxW'(NumWords - 1);

  localparam logic [31:0] ChainInit [NumWords] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_ZERO,
    ST_LEN,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    SRC_IN,
    SRC_MARK,
    SRC_ZERO,
    SRC_LEN
  } byte_src_e;

  typedef enum logic [1:0] {
    GRP_CHOOSE,
    GRP_PARITY0,
    GRP_MAJORITY,
    GRP_PARITY1
  } round_grp_e;

  typedef struct packed {
    logic                push;
    byte_src_e           src;
    logic                load_work;
    logic                round;
    round_grp_e          grp;
    logic                add;
    logic                finish;
    logic [WordIdxW-1:0] out_idx;
  } cmd_t;

  typedef struct packed {
    logic [5:0] pos;
  } status_t;

  function automatic logic [31:0] round_const(round_grp_e grp);
    logic [31:0] k;
    case (grp)
      GRP_CHOOSE:   k = 32'h5a827999;
      GRP_PARITY0:  k = 32'h6ed9eba1;
      GRP_MAJORITY: k = 32'h8f1bbcdc;
      GRP_PARITY1:  k = 32'hca62c1d6;
      default:      k = 32'h5a827999;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/sha1sh_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

`include "sha1_stream_hasher_core_assert.svh"

module sha1sh_ctrl import sha1sh_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire logic                byte_valid_i,
  input  wire logic                end_of_message_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      logic [WordIdxW-1:0] word_index_o,
  output      logic                last_word_o,
  input  wire status_t             status_i,
  output      cmd_t                cmd_o
);

  state_e                state_q, state_d;
  state_e                ret_q, ret_d;
  logic [RoundWidth-1:0] rnd_q, rnd_d;
  logic [WordIdxW-1:0]   widx_q, widx_d;
  logic                  blk_full;

  assign blk_full     = (status_i.pos == LastBytePos);
  assign word_index_o = widx_q;
  assign last_word_o  = (widx_q == LastWordIdx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      rnd_q   <= '0;
      widx_q  <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      rnd_q   <= rnd_d;
      widx_q  <= widx_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    rnd_d       = rnd_q;
    widx_d      = widx_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    cmd_o.src   = SRC_IN;
    cmd_o.grp   = GRP_CHOOSE;
    cmd_o.out_idx = widx_q;

    if (rnd_q inside {[7'd0:7'd19]}) begin
      cmd_o.grp = GRP_CHOOSE;
    end else if (rnd_q inside {[7'd20:7'd39]}) begin
      cmd_o.grp = GRP_PARITY0;
    end else if (rnd_q inside {[7'd40:7'd59]}) begin
      cmd_o.grp = GRP_MAJORITY;
    end else begin
      cmd_o.grp = GRP_PARITY1;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (byte_valid_i) begin
            cmd_o.push = 1'b1;
            cmd_o.src  = SRC_IN;
          end
          if (byte_valid_i && blk_full) begin
            cmd_o.load_work = 1'b1;
            state_d = ST_ROUND;
            ret_d   = end_of_message_i ? ST_MARK : ST_IDLE;
          end else if (end_of_message_i) begin
            state_d = ST_MARK;
          end
        end
      end
      ST_MARK: begin
        cmd_o.push = 1'b1;
        cmd_o.src  = SRC_MARK;
        if (blk_full) begin
          cmd_o.load_work = 1'b1;
          state_d = ST_ROUND;
          ret_d   = ST_ZERO;
        end else begin
          state_d = ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (status_i.pos == LenBytePos) begin
          state_d = ST_LEN;
        end else begin
          cmd_o.push = 1'b1;
          cmd_o.src  = SRC_ZERO;
          if (blk_full) begin
            cmd_o.load_work = 1'b1;
            state_d = ST_ROUND;
            ret_d   = ST_ZERO;
          end
        end
      end
      ST_LEN: begin
        cmd_o.push = 1'b1;
        cmd_o.src  = SRC_LEN;
        if (blk_full) begin
          cmd_o.load_work = 1'b1;
          state_d = ST_ROUND;
          ret_d   = ST_OUT;
        end
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        if (rnd_q == RoundWidth'(NumRounds - 1)) begin
          rnd_d   = '0;
          state_d = ST_ADD;
        end else begin
          rnd_d = rnd_q + 7'd1;
        end
      end
      ST_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = ret_q;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (last_word_o) begin
            cmd_o.finish = 1'b1;
            widx_d  = '0;
            state_d = ST_IDLE;
          end else begin
            widx_d = widx_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `SHA1SH_ASSERT_IMP(a_rnd_in_range, state_q == ST_ROUND, rnd_q < RoundWidth'(NumRounds), "round count out of range")
  `SHA1SH_ASSERT_IMP(a_rnd_idle, state_q != ST_ROUND, rnd_q == '0, "round count not cleared")
  `SHA1SH_ASSERT_NXT(a_full_compress, cmd_o.push && blk_full, state_q == ST_ROUND, "full block did not start compression")
  `SHA1SH_ASSERT_NXT(a_add_return, state_q == ST_ADD, state_q == $past(ret_q), "compression returned to wrong state")
  `SHA1SH_ASSERT_NXT(a_last_idle, out_valid_o && out_ready_i && last_word_o, (state_q == ST_IDLE) && (widx_q == '0), "digest end did not return to idle")

endmodule

`default_nettype wire

FILE: hdl/sha1sh_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module sha1sh_dp import sha1sh_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [7:0]  byte_value_i,
  input  wire cmd_t        cmd_i,
  output      status_t     status_o,
  output      logic [31:0] digest_word_o
);

  logic [31:0] h_q [NumWords];
  logic [63:0] count_q;
  logic [31:0] w_q [SchedWords];
  logic [23:0] acc_q;
  logic [63:0] len_q;
  logic [31:0] a_q, b_q, c_q, d_q, e_q;

  logic [7:0]  push_byte;
  logic [31:0] sched_mix;
  logic [31:0] sched_new;
  logic [31:0] f_val;
  logic [31:0] t_val;

  assign status_o.pos  = count_q[5:0];
  assign digest_word_o = h_q[cmd_i.out_idx];

  always_comb begin
    case (cmd_i.src)
      SRC_IN:   push_byte = byte_value_i;
      SRC_MARK: push_byte = PadMark;
      SRC_ZERO: push_byte = 8'h00;
      SRC_LEN:  push_byte = len_q[63:56];
      default:  push_byte = 8'h00;
    endcase
  end

  assign sched_mix = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
  assign sched_new = {sched_mix[30:0], sched_mix[31]};

  always_comb begin
    case (cmd_i.grp)
      GRP_CHOOSE:   f_val = (b_q & c_q) | (~b_q & d_q);
      GRP_MAJORITY: f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      default:      f_val = b_q ^ c_q ^ d_q;
    endcase
  end

  assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + round_const(cmd_i.grp) + w_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q     <= ChainInit;
      count_q <= '0;
    end else begin
      if (cmd_i.finish) begin
        h_q     <= ChainInit;
        count_q <= '0;
      end else begin
        if (cmd_i.push) begin
          count_q <= count_q + 64'd1;
        end
        if (cmd_i.add) begin
          h_q[0] <= h_q[0] + a_q;
          h_q[1] <= h_q[1] + b_q;
          h_q[2] <= h_q[2] + c_q;
          h_q[3] <= h_q[3] + d_q;
          h_q[4] <= h_q[4] + e_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      if (count_q[1:0] == 2'd3) begin
        for (int i = 0; i < SchedWords - 1; i++) begin
          w_q[i] <= w_q[i+1];
        end
        w_q[SchedWords-1] <= {acc_q, push_byte};
      end else begin
        acc_q <= {acc_q[15:0], push_byte};
      end
      if (cmd_i.src == SRC_MARK) begin
        len_q <= {count_q[60:0], 3'b000};
      end else if (cmd_i.src == SRC_LEN) begin
        len_q <= {len_q[55:0], 8'h00};
      end
    end else if (cmd_i.round) begin
      for (int i = 0; i < SchedWords - 1; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[SchedWords-1] <= sched_new;
    end

    if (cmd_i.load_work) begin
      a_q <= h_q[0];
      b_q <= h_q[1];
      c_q <= h_q[2];
      d_q <= h_q[3];
      e_q <= h_q[4];
    end else if (cmd_i.round) begin
      a_q <= t_val;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sha1_stream_hasher_core.sv
// Streaming SHA-1 hasher. Each input transfer carries at most one message byte and an
// end-of-message flag; bytes are accepted one per cycle while the core is idle. Every
// 64th byte starts a compression on a single round unit (80 rounds at one per cycle,
// then the chaining add), during which in_ready_o is low. After an end-of-message
// transfer the core appends padding and the length one byte per cycle, except while a
// compression runs, with one step that pushes no byte before the length (at most 72
// bytes), runs one or two compressions, and then presents the five digest words, word 0
// first, with last_word_o set on word 4; the next message is accepted once the last
// word transfer completes.
`timescale 1ns / 1ps
`default_nettype none

module sha1_stream_hasher_core import sha1sh_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire logic [7:0]          byte_value_i,
  input  wire logic                byte_valid_i,
  input  wire logic                end_of_message_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      logic [31:0]         digest_word_o,
  output      logic [WordIdxW-1:0] word_index_o,
  output      logic                last_word_o
);

  cmd_t    cmd;
  status_t status;

  sha1sh_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .byte_valid_i     (byte_valid_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .word_index_o     (word_index_o),
    .last_word_o      (last_word_o),
    .status_i         (status),
    .cmd_o            (cmd)
  );

  sha1sh_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_value_i  (byte_value_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .digest_word_o (digest_word_o)
  );

endmodule

`default_nettype wire
